FILE: rtl/sse_pkg.sv
// Package for the substring search engine: request and register codes,
// the per-cell control struct, the result struct and ASCII case folding.
// Depends on nothing; every other file imports it.
package sse_pkg;

  localparam int PATTERN_MAX_DEF = 64;
  localparam int IDX_W           = 6;
  localparam int CHAR_W          = 8;
  localparam int CFG_LEN_W       = 7;
  localparam int DIST_W          = 32;
  localparam int APB_ADDR_W      = 4;
  localparam int APB_DATA_W      = 32;
  localparam int IN_DATA_W       = 16;

  typedef enum logic [1:0] {
    REQ_PATTERN = 2'd0,
    REQ_TEXT    = 2'd1,
    REQ_REARM   = 2'd2
  } req_type_e;

  typedef enum logic [1:0] {
    REG_PAT_LEN    = 2'd0,
    REG_CASE_EXACT = 2'd1,
    REG_SEARCH_REV = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic              step;
    logic              rearm;
    logic              remap;
    logic              reverse;
    logic              case_exact;
    logic [CHAR_W-1:0] text_char;
    logic [CHAR_W-1:0] pat_char;
  } cell_ctrl_t;

  typedef struct packed {
    logic              found;
    logic [DIST_W-1:0] distance;
  } result_t;

  function automatic logic [CHAR_W-1:0] fold_lower(input logic [CHAR_W-1:0] c);
    if (c >= 8'h41 && c <= 8'h5a) begin
      return c + 8'h20;
    end
    return c;
  endfunction

endpackage

FILE: rtl/substring_search_engine.sv
// Substring search engine top level: config registers, position counter,
// a row of compare cells and the result buffer.
// Depends on sse_pkg, sse_cell and sse_out_skid.
//
//   port group   dir   content
//   s_axis_*     in    tuser: req_type; tdata: pattern_index, char_value
//   m_axis_*     out   tuser: found; tdata: match_distance
//   APB          in    pattern_length, case_exact, search_reverse at 0, 4, 8
//
// One transfer per cycle while s_axis_tready is high: every cell updates its bit in the same cycle,
// so the row of PATTERN_MAX cells sets the rate, not the pattern length.
// A result is registered in the result buffer before it appears on m_axis.
// s_axis_tready drops only when two results wait downstream.
// Reset clears the partial matches and position and sets the registers to length 1, case exact,
// forward; the pattern bytes stay undefined until loaded.
module substring_search_engine #(
  parameter int PATTERN_MAX = sse_pkg::PATTERN_MAX_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [sse_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // [5:0] pattern_index, [13:6] char_value
  input  logic [1:0]                     s_axis_tuser,  // [1:0] req_type
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [sse_pkg::DIST_W-1:0]     m_axis_tdata,  // [31:0] match_distance
  output logic                           m_axis_tuser,  // [0] found
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [sse_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [sse_pkg::APB_DATA_W-1:0] pwdata,
  output logic [sse_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);
  import sse_pkg::*;

  localparam int LEN_W  = $clog2(PATTERN_MAX + 1);
  localparam int PIDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int CMP_W  = (LEN_W > CFG_LEN_W) ? LEN_W : CFG_LEN_W;

  function automatic logic [LEN_W-1:0] eff_len(input logic [CFG_LEN_W-1:0] raw);
    logic [CMP_W-1:0] r;
    r = CMP_W'(raw);
    if (r == '0) begin
      return LEN_W'(1);
    end
    if (r > CMP_W'(PATTERN_MAX)) begin
      return LEN_W'(PATTERN_MAX);
    end
    return LEN_W'(r);
  endfunction

  logic [CFG_LEN_W-1:0] len_raw_q, len_raw_d;
  logic                 case_exact_q, case_exact_d;
  logic                 rev_q, rev_d;
  logic [DIST_W-1:0]    pos_q, pos_d;
  logic                 done_q, done_d;
  logic [PATTERN_MAX-1:0] extra_q, extra_d;

  logic                 in_acc, cfg_wr, text_step, rearm, pat_load, any_hit, res_push;
  logic                 buf_full;
  reg_idx_e             reg_sel;
  req_type_e            kind;
  logic [LEN_W-1:0]     len_eff, len_m1, new_len, new_m1;
  logic                 new_rev;
  logic [CHAR_W-1:0]    text_char;
  logic [DIST_W-1:0]    dist_fwd, len_m1_ext;
  result_t              res_d, res_out;
  cell_ctrl_t           ctrl;

  logic [PATTERN_MAX-1:0] cell_state, hit_vec, jvec, pvec;
  logic [LEN_W-1:0]       old_idx [PATTERN_MAX];
  logic [LEN_W-1:0]       new_idx [PATTERN_MAX];

  assign pready  = 1'b1;
  assign reg_sel = reg_idx_e'(paddr[3:2]);
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign in_acc  = s_axis_tvalid & s_axis_tready;
  assign kind    = req_type_e'(s_axis_tuser);

  always_comb begin
    text_step = 1'b0;
    rearm     = 1'b0;
    pat_load  = 1'b0;
    case (kind)
      REQ_PATTERN: pat_load  = in_acc;
      REQ_TEXT:    text_step = in_acc & ~done_q;
      REQ_REARM:   rearm     = in_acc;
      default:     ;
    endcase
  end

  // Config registers and read-back
  always_comb begin
    len_raw_d    = len_raw_q;
    case_exact_d = case_exact_q;
    rev_d        = rev_q;
    prdata       = '0;
    case (reg_sel)
      REG_PAT_LEN: begin
        if (cfg_wr) len_raw_d = pwdata[CFG_LEN_W-1:0];
        prdata = APB_DATA_W'(len_raw_q);
      end
      REG_CASE_EXACT: begin
        if (cfg_wr) case_exact_d = pwdata[0];
        prdata = APB_DATA_W'(case_exact_q);
      end
      REG_SEARCH_REV: begin
        if (cfg_wr) rev_d = pwdata[0];
        prdata = APB_DATA_W'(rev_q);
      end
      default: ;
    endcase
  end

  assign len_eff = eff_len(len_raw_q);
  assign len_m1  = len_eff - LEN_W'(1);
  assign new_len = eff_len(len_raw_d);
  assign new_m1  = new_len - LEN_W'(1);
  assign new_rev = rev_d;

  // Re-index partial matches when length or direction changes
  always_comb begin
    for (int j = 0; j < PATTERN_MAX; j++) begin
      old_idx[j] = len_m1 - LEN_W'(j);
      new_idx[j] = new_m1 - LEN_W'(j);
    end
    for (int j = 0; j < PATTERN_MAX; j++) begin
      if (rev_q) begin
        jvec[j] = extra_q[j] |
                  ((LEN_W'(j) < len_eff) & cell_state[old_idx[j][PIDX_W-1:0]]);
      end else begin
        jvec[j] = extra_q[j] | cell_state[j];
      end
    end
    for (int p = 0; p < PATTERN_MAX; p++) begin
      if (new_rev) begin
        pvec[p]    = (LEN_W'(p) < new_len) & jvec[new_idx[p][PIDX_W-1:0]];
        extra_d[p] = (LEN_W'(p) >= new_len) & jvec[p];
      end else begin
        pvec[p]    = jvec[p];
        extra_d[p] = 1'b0;
      end
    end
  end

  always_comb begin
    text_char = {1'b0, s_axis_tdata[IDX_W+CHAR_W-2:IDX_W]};
    if (!case_exact_q) text_char = fold_lower(text_char);
    ctrl.step       = text_step;
    ctrl.rearm      = rearm;
    ctrl.remap      = cfg_wr;
    ctrl.reverse    = rev_q;
    ctrl.case_exact = case_exact_q;
    ctrl.text_char  = text_char;
    ctrl.pat_char   = s_axis_tdata[IDX_W+CHAR_W-1:IDX_W];
  end

  for (genvar g = 0; g < PATTERN_MAX; g++) begin : g_cell
    logic we, left_b, right_b;
    assign we      = pat_load & (32'(s_axis_tdata[IDX_W-1:0]) == 32'(g));
    assign left_b  = (g == 0) ? 1'b0 : cell_state[(g == 0) ? 0 : g - 1];
    assign right_b = (g == PATTERN_MAX - 1) ? 1'b0
                   : cell_state[(g == PATTERN_MAX - 1) ? g : g + 1];
    sse_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .pat_we_i   (we),
      .active_i   (LEN_W'(g) < len_eff),
      .start_i    (rev_q ? (LEN_W'(g) == len_m1) : (g == 0)),
      .last_i     (rev_q ? (g == 0) : (LEN_W'(g) == len_m1)),
      .left_i     (left_b),
      .right_i    (right_b),
      .remap_bit_i(pvec[g]),
      .state_o    (cell_state[g]),
      .hit_o      (hit_vec[g])
    );
  end

  assign any_hit    = |hit_vec;
  assign len_m1_ext = DIST_W'(len_m1);
  assign dist_fwd   = (pos_q >= len_m1_ext) ? (pos_q - len_m1_ext) : '0;

  always_comb begin
    pos_d    = pos_q;
    done_d   = done_q;
    res_push = 1'b0;
    res_d    = '0;
    if (rearm) begin
      pos_d    = '0;
      done_d   = 1'b0;
      res_push = ~done_q;
    end else if (text_step) begin
      if (pos_q != '1) pos_d = pos_q + DIST_W'(1);
      if (any_hit) begin
        done_d         = 1'b1;
        res_push       = 1'b1;
        res_d.found    = 1'b1;
        res_d.distance = rev_q ? pos_q : dist_fwd;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_raw_q    <= CFG_LEN_W'(1);
      case_exact_q <= 1'b1;
      rev_q        <= 1'b0;
      pos_q        <= '0;
      done_q       <= 1'b0;
      extra_q      <= '0;
    end else begin
      len_raw_q    <= len_raw_d;
      case_exact_q <= case_exact_d;
      rev_q        <= rev_d;
      pos_q        <= pos_d;
      done_q       <= done_d;
      if (rearm || text_step) begin
        extra_q <= '0;
      end else if (cfg_wr) begin
        extra_q <= extra_d;
      end
    end
  end

  sse_out_skid u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (res_push),
    .push_data_i(res_d),
    .full_o     (buf_full),
    .valid_o    (m_axis_tvalid),
    .pop_i      (m_axis_tready),
    .data_o     (res_out)
  );

  assign s_axis_tready = ~buf_full;
  assign m_axis_tdata  = res_out.distance;
  assign m_axis_tuser  = res_out.found;

  a_one_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(hit_vec))
    else $error("more than one cell reports a completed match");

  a_hit_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (text_step && any_hit) |=> done_q)
    else $error("match completed without closing the search");

  a_rearm_clr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rearm |=> (pos_q == '0 && !done_q && cell_state == '0))
    else $error("rearm left search state behind");

endmodule

FILE: rtl/sse_cell.sv
// One compare cell: holds one pattern byte and one partial-match bit.
// Takes the neighbor bits from both sides; direction follows reverse mode.
// Depends on sse_pkg.
module sse_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sse_pkg::cell_ctrl_t ctrl_i,
  input  logic              pat_we_i,
  input  logic              active_i,
  input  logic              start_i,
  input  logic              last_i,
  input  logic              left_i,
  input  logic              right_i,
  input  logic              remap_bit_i,
  output logic              state_o,
  output logic              hit_o
);
  import sse_pkg::*;

  logic [CHAR_W-1:0] pat_q, pat_d;
  logic [CHAR_W-1:0] pat_cmp;
  logic              state_q, state_d;
  logic              chain_in, step_bit;

  always_comb begin
    pat_d    = pat_we_i ? ctrl_i.pat_char : pat_q;
    pat_cmp  = ctrl_i.case_exact ? pat_q : fold_lower(pat_q);
    chain_in = start_i | (ctrl_i.reverse ? right_i : left_i);
    step_bit = active_i & (pat_cmp == ctrl_i.text_char) & chain_in;
    if (ctrl_i.rearm) begin
      state_d = 1'b0;
    end else if (ctrl_i.remap) begin
      state_d = remap_bit_i;
    end else if (ctrl_i.step) begin
      state_d = step_bit;
    end else begin
      state_d = state_q;
    end
  end

  always_ff @(posedge clk_i) begin
    pat_q <= pat_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= 1'b0;
    end else begin
      state_q <= state_d;
    end
  end

  assign state_o = state_q;
  assign hit_o   = ctrl_i.step & step_bit & last_i;

endmodule

FILE: rtl/sse_out_skid.sv
// Two-slot result buffer: a head register and a skid register.
// Lets the engine take a transfer while a result waits downstream.
// Depends on sse_pkg.
module sse_out_skid (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  sse_pkg::result_t push_data_i,
  output logic             full_o,
  output logic             valid_o,
  input  logic             pop_i,
  output sse_pkg::result_t data_o
);
  import sse_pkg::*;

  result_t head_q, head_d, skid_q, skid_d;
  logic    head_v_q, head_v_d, skid_v_q, skid_v_d;

  always_comb begin
    head_v_d = head_v_q & ~pop_i;
    head_d   = head_q;
    skid_v_d = skid_v_q;
    skid_d   = skid_q;
    if (!head_v_d && skid_v_d) begin
      head_v_d = 1'b1;
      head_d   = skid_q;
      skid_v_d = 1'b0;
    end
    if (push_i) begin
      if (!head_v_d) begin
        head_v_d = 1'b1;
        head_d   = push_data_i;
      end else begin
        skid_v_d = 1'b1;
        skid_d   = push_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    skid_q <= skid_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      head_v_q <= head_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  assign full_o  = skid_v_q;
  assign valid_o = head_v_q;
  assign data_o  = head_q;

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps
// Testbench for substring_search_engine: streams pattern loads, text and rearm transfers,
// sets the registers over APB and checks each result against an in-bench search model.
// Depends on sse_pkg and the substring_search_engine RTL.
module tb;
  import sse_pkg::*;

  localparam logic [1:0]  REQ_RESERVED   = 2'd3;
  localparam int unsigned N_CELLS        = PATTERN_MAX_DEF;
  localparam int unsigned RX_HOLD_CYCLES = 400;
  localparam int unsigned RAND_TARGET    = 1350;
  localparam logic [63:0] ALPHABET       = 64'h61_62_41_42_40_5b_60_7b;

  typedef struct packed {
    logic [1:0]        kind;
    logic [IDX_W-1:0]  idx;
    logic [CHAR_W-1:0] ch;
  } search_req_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;  // [5:0] pattern_index, [13:6] char_value
  logic [1:0]            s_axis_tuser  = '0;  // [1:0] req_type
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [DIST_W-1:0]     m_axis_tdata;        // [31:0] match_distance
  logic                  m_axis_tuser;        // [0] found
  logic                  psel          = 1'b0;
  logic                  penable       = 1'b0;
  logic                  pwrite        = 1'b0;
  logic [APB_ADDR_W-1:0] paddr         = '0;
  logic [APB_DATA_W-1:0] pwdata        = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  // search model state
  logic [CHAR_W-1:0]    pat_mem [N_CELLS];
  logic [N_CELLS-1:0]   cell_hit       = '0;
  logic [DIST_W-1:0]    text_pos       = '0;
  logic                 hit_done       = 1'b0;
  logic [CFG_LEN_W-1:0] cfg_len        = 7'd1;
  logic                 cfg_case_exact = 1'b1;
  logic                 cfg_reverse    = 1'b0;

  result_t     hit_reports_q[$];
  search_req_t search_req_q[$];

  // stimulus generator state
  logic [CHAR_W-1:0] gen_pat [N_CELLS];
  int unsigned       gen_len = 1;
  bit                gen_case = 1'b1;
  bit                gen_rev = 1'b0;
  int unsigned       load_order [N_CELLS];
  int unsigned       stim_count = 0;

  search_req_t tx_item;
  int unsigned tx_gap = 0;
  int unsigned rx_wait = 0;
  int unsigned rx_hold_left = 0;
  bit          rx_hold_req = 1'b0;
  bit          tx_calm = 1'b0;
  bit          rx_calm = 1'b0;
  result_t     mon_want;
  int unsigned mon_errors = 0;
  int unsigned cfg_errors = 0;

  substring_search_engine DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #4 clk_i = ~clk_i;

  function automatic logic [CHAR_W-1:0] ascii_lower(input logic [CHAR_W-1:0] c);
    if (c >= 8'h41 && c <= 8'h5a) begin
      return c + 8'h20;
    end
    return c;
  endfunction

  function automatic int unsigned clamp_len(input logic [CFG_LEN_W-1:0] v);
    if (v == 0) begin
      return 1;
    end
    if (v > N_CELLS) begin
      return N_CELLS;
    end
    return v;
  endfunction

  function automatic void track_search(input search_req_t r);
    int unsigned       len;
    int unsigned       p;
    int unsigned       j;
    logic [CHAR_W-1:0] t;
    logic [CHAR_W-1:0] pc;
    logic [N_CELLS-1:0] nxt;
    logic [DIST_W-1:0] k;
    result_t           res;
    case (r.kind)
      REQ_PATTERN: begin
        pat_mem[r.idx] = r.ch;
      end
      REQ_REARM: begin
        if (!hit_done) begin
          res.found    = 1'b0;
          res.distance = '0;
          hit_reports_q.push_back(res);
        end
        cell_hit = '0;
        text_pos = '0;
        hit_done = 1'b0;
      end
      REQ_TEXT: begin
        if (!hit_done) begin
          len = clamp_len(cfg_len);
          t   = {1'b0, r.ch[6:0]};
          if (!cfg_case_exact) t = ascii_lower(t);
          nxt = '0;
          for (j = 0; j < len; j++) begin
            p  = cfg_reverse ? len - 1 - j : j;
            pc = pat_mem[p];
            if (!cfg_case_exact) pc = ascii_lower(pc);
            nxt[j] = (pc == t) && (j == 0 || cell_hit[j-1]);
          end
          cell_hit = nxt;
          k = text_pos;
          if (text_pos != '1) text_pos = text_pos + 1;
          if (cell_hit[len-1]) begin
            hit_done     = 1'b1;
            res.found    = 1'b1;
            res.distance = cfg_reverse ? k : ((k >= len - 1) ? k - (len - 1) : '0);
            hit_reports_q.push_back(res);
          end
        end
      end
      default: begin
      end
    endcase
  endfunction

  function automatic int unsigned idle_draw(input bit calm);
    if (calm || $urandom_range(0, 2) == 0) begin
      return 0;
    end
    return $urandom_range(0, 13);
  endfunction

  function automatic void push_req(input logic [1:0] kind, input int unsigned idx,
                                   input int unsigned ch);
    search_req_t r;
    r.kind = kind;
    r.idx  = idx[IDX_W-1:0];
    r.ch   = ch[CHAR_W-1:0];
    search_req_q.push_back(r);
    if (kind != REQ_RESERVED) stim_count++;
  endfunction

  function automatic logic [CHAR_W-1:0] pick_char(input bit allow_wide);
    int unsigned v;
    if (allow_wide && $urandom_range(0, 9) == 0) begin
      v = $urandom_range(0, 255);
      return v[CHAR_W-1:0];
    end
    v = 8 * $urandom_range(0, 7);
    return ALPHABET[v +: 8];
  endfunction

  function automatic logic [CHAR_W-1:0] embed_char(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] v;
    v = c;
    if (!gen_case && ((v >= 8'h41 && v <= 8'h5a) || (v >= 8'h61 && v <= 8'h7a)) &&
        $urandom_range(0, 1) == 1) begin
      v[5] = ~v[5];
    end
    if ($urandom_range(0, 4) == 0) v[7] = 1'b1;
    return v;
  endfunction

  function automatic void queue_text(input logic [CHAR_W-1:0] c);
    int unsigned roll;
    int unsigned at;
    roll = $urandom_range(0, 59);
    if (roll == 0) begin
      push_req(REQ_RESERVED, $urandom_range(0, 63), $urandom_range(0, 255));
    end else if (roll == 1) begin
      at = $urandom_range(0, N_CELLS - 1);
      gen_pat[at] = pick_char(gen_len <= 8);
      push_req(REQ_PATTERN, at, gen_pat[at]);
    end else if (roll == 2) begin
      push_req(REQ_REARM, $urandom_range(0, 63), $urandom_range(0, 255));
    end
    push_req(REQ_TEXT, $urandom_range(0, 63), c);
  endfunction

  function automatic void queue_search(input bit with_rearm);
    int unsigned i;
    int unsigned n;
    n = $urandom_range(0, 12);
    for (i = 0; i < n; i++) queue_text(pick_char(1'b1));
    if ($urandom_range(0, 9) < 6) begin
      for (i = 0; i < gen_len; i++) begin
        queue_text(embed_char(gen_pat[gen_rev ? gen_len - 1 - i : i]));
      end
    end
    n = $urandom_range(0, 6);
    for (i = 0; i < n; i++) queue_text(pick_char(1'b1));
    if (with_rearm) push_req(REQ_REARM, $urandom_range(0, 63), $urandom_range(0, 255));
  endfunction

  task automatic reg_set(input reg_idx_e id, input int unsigned field);
    logic [APB_DATA_W-1:0] junk;
    logic [APB_DATA_W-1:0] wdata;
    logic [APB_DATA_W-1:0] want;
    junk = $urandom();
    if (id == REG_PAT_LEN) begin
      wdata = {junk[APB_DATA_W-1:CFG_LEN_W], field[CFG_LEN_W-1:0]};
      want  = {{(APB_DATA_W-CFG_LEN_W){1'b0}}, field[CFG_LEN_W-1:0]};
    end else begin
      wdata = {junk[APB_DATA_W-1:1], field[0]};
      want  = {{(APB_DATA_W-1){1'b0}}, field[0]};
    end
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {id, 2'b00};
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    case (id)
      REG_PAT_LEN:    cfg_len        <= field[CFG_LEN_W-1:0];
      REG_CASE_EXACT: cfg_case_exact <= field[0];
      default:        cfg_reverse    <= field[0];
    endcase
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== want) begin
      $error("prdata: expected %0h, got %0h", want, prdata);
      cfg_errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic wait_idle();
    while (search_req_q.size() != 0 || s_axis_tvalid || hit_reports_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) track_search(tx_item);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (tx_gap != 0) begin
          tx_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (search_req_q.size() != 0) begin
          tx_item = search_req_q.pop_front();
          s_axis_tuser  <= tx_item.kind;
          s_axis_tdata  <= {2'b00, tx_item.ch, tx_item.idx};
          s_axis_tvalid <= 1'b1;
          tx_gap = idle_draw(tx_calm);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_hold_left <= 0;
    end else if (rx_hold_req) begin
      rx_hold_left <= RX_HOLD_CYCLES;
    end else if (rx_hold_left != 0) begin
      rx_hold_left <= rx_hold_left - 1;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (hit_reports_q.size() == 0) begin
          $error("result with none expected: found %0b, match_distance %0d",
                 m_axis_tuser, m_axis_tdata);
          mon_errors++;
        end else begin
          mon_want = hit_reports_q.pop_front();
          if (m_axis_tuser !== mon_want.found) begin
            $error("found: expected %0b, got %0b", mon_want.found, m_axis_tuser);
            mon_errors++;
          end
          if (m_axis_tdata !== mon_want.distance) begin
            $error("match_distance: expected %0d, got %0d", mon_want.distance, m_axis_tdata);
            mon_errors++;
          end
        end
        rx_wait = idle_draw(rx_calm);
      end
      if (rx_hold_left != 0) begin
        m_axis_tready <= 1'b0;
      end else if (rx_wait != 0) begin
        rx_wait--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin
    #5_000_000;
    $display("** substring_search_engine: FAILED **");
    $finish;
  end

  initial begin
    int unsigned len_field;
    int unsigned roll;
    int unsigned n;
    int unsigned i;
    int unsigned j;
    int unsigned tmp;
    int unsigned phase;
    int unsigned stim_base;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // exact forward search, bit 7 stripping, miss, reserved request
    reg_set(REG_PAT_LEN, 3);
    reg_set(REG_CASE_EXACT, 1);
    reg_set(REG_SEARCH_REV, 0);
    push_req(REQ_PATTERN, 0, 8'h61);
    push_req(REQ_PATTERN, 1, 8'h42);
    push_req(REQ_PATTERN, 2, 8'h63);
    push_req(REQ_TEXT, 63, 8'h78);
    push_req(REQ_TEXT, 0, 8'h61);
    push_req(REQ_TEXT, 21, 8'h42);
    push_req(REQ_TEXT, 42, 8'h63);
    push_req(REQ_TEXT, 0, 8'h61);
    push_req(REQ_REARM, 63, 8'hff);
    push_req(REQ_TEXT, 0, 8'he1);
    push_req(REQ_TEXT, 0, 8'hc2);
    push_req(REQ_TEXT, 0, 8'he3);
    push_req(REQ_REARM, 0, 8'h00);
    push_req(REQ_TEXT, 0, 8'h61);
    push_req(REQ_TEXT, 0, 8'h62);
    push_req(REQ_TEXT, 0, 8'h63);
    push_req(REQ_REARM, 0, 8'h00);
    push_req(REQ_RESERVED, 63, 8'hff);
    wait_idle();

    // folded compare, then backward search ending at the buffer start
    reg_set(REG_CASE_EXACT, 0);
    push_req(REQ_TEXT, 0, 8'h41);
    push_req(REQ_TEXT, 0, 8'h62);
    push_req(REQ_TEXT, 0, 8'h43);
    push_req(REQ_REARM, 0, 8'h00);
    wait_idle();
    reg_set(REG_SEARCH_REV, 1);
    push_req(REQ_TEXT, 0, 8'h63);
    push_req(REQ_TEXT, 0, 8'h62);
    push_req(REQ_TEXT, 0, 8'h61);
    push_req(REQ_REARM, 0, 8'h00);
    push_req(REQ_REARM, 0, 8'h00);
    wait_idle();

    // pattern byte with bit 7 set never matches
    reg_set(REG_PAT_LEN, 1);
    reg_set(REG_CASE_EXACT, 1);
    reg_set(REG_SEARCH_REV, 0);
    push_req(REQ_PATTERN, 0, 8'he1);
    push_req(REQ_TEXT, 0, 8'he1);
    push_req(REQ_TEXT, 0, 8'h61);
    push_req(REQ_REARM, 0, 8'h00);
    wait_idle();

    // fill the result path while the receiver holds off
    push_req(REQ_PATTERN, 0, 8'h61);
    tx_calm <= 1'b1;
    for (i = 0; i < 60; i++) begin
      push_req(REQ_TEXT, $urandom_range(0, 63), ($urandom_range(0, 1) == 1) ? 8'h61 : 8'h62);
      push_req(REQ_REARM, $urandom_range(0, 63), $urandom_range(0, 255));
    end
    rx_hold_req <= 1'b1;
    @(posedge clk_i);
    rx_hold_req <= 1'b0;
    wait_idle();
    tx_calm <= 1'b0;

    stim_base = stim_count;
    phase = 0;
    while (stim_count - stim_base < RAND_TARGET) begin
      wait_idle();
      case (phase)
        0: len_field = 64;
        1: len_field = 127;
        2: len_field = 0;
        3: len_field = 65;
        default: begin
          roll = $urandom_range(0, 99);
          if (roll < 65) len_field = $urandom_range(1, 6);
          else if (roll < 88) len_field = $urandom_range(7, 20);
          else if (roll < 97) len_field = $urandom_range(21, 64);
          else len_field = $urandom_range(65, 127);
        end
      endcase
      gen_case = 1'($urandom_range(0, 1));
      gen_rev  = 1'($urandom_range(0, 1));
      gen_len  = clamp_len(len_field[CFG_LEN_W-1:0]);
      reg_set(REG_PAT_LEN, len_field);
      reg_set(REG_CASE_EXACT, gen_case);
      reg_set(REG_SEARCH_REV, gen_rev);
      tx_calm <= ($urandom_range(0, 3) == 0);
      rx_calm <= ($urandom_range(0, 3) == 0);

      for (i = 0; i < gen_len; i++) load_order[i] = i;
      for (i = gen_len; i > 1; i--) begin
        j = $urandom_range(0, i - 1);
        tmp = load_order[i-1];
        load_order[i-1] = load_order[j];
        load_order[j] = tmp;
      end
      for (i = 0; i < gen_len; i++) begin
        gen_pat[load_order[i]] = pick_char(gen_len <= 8);
        push_req(REQ_PATTERN, load_order[i], gen_pat[load_order[i]]);
      end

      n = $urandom_range(1, 4);
      for (i = 0; i < n; i++) queue_search(i != n - 1 || $urandom_range(0, 9) != 0);
      phase++;
    end

    wait_idle();
    repeat (20) @(posedge clk_i);
    if (mon_errors == 0 && cfg_errors == 0 && hit_reports_q.size() == 0) begin
      $display("** substring_search_engine: PASSED **");
    end else begin
      $display("** substring_search_engine: FAILED **");
    end
    $finish;
  end

endmodule
